@@ rtl/qlt_pkg.sv @@
// Shared types, token codes and byte classifiers for the query tokenizer.
// No dependencies; used by every module of the block.
package qlt_pkg;

  localparam longint MaxQueryBytes = 1048576;
  localparam int OffW = 20;
  localparam logic [OffW-1:0] OffMax = '1;
  localparam logic [OffW-1:0] PosLimit =
    (MaxQueryBytes - 1 > longint'(OffMax)) ? OffMax : OffW'(MaxQueryBytes - 1);

  localparam logic [1:0] KindToken   = 2'd0;
  localparam logic [1:0] KindContent = 2'd1;
  localparam logic [1:0] KindError   = 2'd2;

  localparam logic [5:0] TokEnd     = 6'd0;
  localparam logic [5:0] TokInvalid = 6'd1;
  localparam logic [5:0] TokString  = 6'd2;
  localparam logic [5:0] TokNumber  = 6'd3;
  localparam logic [5:0] TokIdent   = 6'd4;
  localparam logic [5:0] TokShr     = 6'd5;
  localparam logic [5:0] TokAssign  = 6'd6;
  localparam logic [5:0] TokGe      = 6'd7;
  localparam logic [5:0] TokLe      = 6'd8;
  localparam logic [5:0] TokNe      = 6'd9;
  localparam logic [5:0] TokEqEq    = 6'd10;
  localparam logic [5:0] TokArrow   = 6'd11;
  localparam logic [5:0] TokRange   = 6'd12;

  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChHigh   = 8'h80;

  typedef struct packed {
    logic [1:0]      kind;
    logic [5:0]      token_type;
    logic [OffW-1:0] start_offset;
    logic [OffW-1:0] token_length;
    logic [7:0]      content_byte;
    logic            last_of_run;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } res_pair_t;

  function automatic result_t mk_res(logic [1:0] kind, logic [5:0] ttype,
                                     logic [OffW-1:0] start, logic [OffW-1:0] len,
                                     logic [7:0] cbyte);
    result_t r;
    r.kind         = kind;
    r.token_type   = ttype;
    r.start_offset = start;
    r.token_length = len;
    r.content_byte = cbyte;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  function automatic logic starts_name(logic [7:0] b);
    return (b inside {["a":"z"], ["A":"Z"], "_"}) || (b >= ChHigh);
  endfunction

  function automatic logic extends_name(logic [7:0] b);
    return starts_name(b) || is_digit(b) || (b == "-");
  endfunction

  function automatic logic is_pend_start(logic [7:0] b);
    return b inside {"-", ".", ">", ":", "<", "!", "="};
  endfunction

  function automatic logic [5:0] single_type(logic [7:0] b);
    logic [5:0] t;
    case (b)
      "=":     t = 6'd13;
      "<":     t = 6'd14;
      ">":     t = 6'd15;
      "!":     t = 6'd16;
      "-":     t = 6'd17;
      "|":     t = 6'd18;
      "&":     t = 6'd19;
      "+":     t = 6'd20;
      "*":     t = 6'd21;
      "?":     t = 6'd22;
      ":":     t = 6'd23;
      ";":     t = 6'd24;
      ",":     t = 6'd25;
      ".":     t = 6'd26;
      "(":     t = 6'd27;
      ")":     t = 6'd28;
      "[":     t = 6'd29;
      "]":     t = 6'd30;
      "{":     t = 6'd31;
      "}":     t = 6'd32;
      "/":     t = 6'd33;
      8'h5C:   t = 6'd34;
      "$":     t = 6'd35;
      "@":     t = 6'd36;
      "^":     t = 6'd37;
      "~":     t = 6'd38;
      "%":     t = 6'd39;
      default: t = TokInvalid;
    endcase
    return t;
  endfunction

  // TokEnd means no pair
  function automatic logic [5:0] pair_type(logic [7:0] c, logic [7:0] b);
    logic [5:0] t;
    t = TokEnd;
    if (c == ">" && b == ">") t = TokShr;
    else if (c == ":" && b == "=") t = TokAssign;
    else if (c == ">" && b == "=") t = TokGe;
    else if (c == "<" && b == "=") t = TokLe;
    else if (c == "!" && b == "=") t = TokNe;
    else if (c == "=" && b == "=") t = TokEqEq;
    else if (c == "-" && b == ">") t = TokArrow;
    else if (c == "." && b == ".") t = TokRange;
    return t;
  endfunction

endpackage

@@ rtl/qlt_scan.sv @@
// Scanner state and single-pass decode: one word in, up to two results out.
// Depends on qlt_pkg.
module qlt_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          in_byte_i,
  input  logic                end_mark_i,
  output qlt_pkg::res_pair_t  res_o
);

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_STRING, M_NUMBER, M_IDENT, M_PEND
  } mode_e;

  typedef enum logic [1:0] {
    PH_INT, PH_FRAC, PH_EXPSIGN, PH_EXPDIG
  } phase_e;

  mode_e                      mode_q, mode_d;
  phase_e                     phase_q, phase_d;
  logic [7:0]                 pend_q, pend_d;
  logic                       esc_q, esc_d;
  logic [qlt_pkg::OffW-1:0]   start_q, start_d;
  logic [qlt_pkg::OffW-1:0]   pos_q, pos_d;

  qlt_pkg::result_t ea, eb;
  logic             ea_v, eb_v, disp, num_take;
  logic [5:0]       pt;
  logic [7:0]       b;

  assign b = in_byte_i;

  always_comb begin
    mode_d   = mode_q;
    phase_d  = phase_q;
    pend_d   = pend_q;
    esc_d    = esc_q;
    start_d  = start_q;
    pos_d    = pos_q;
    ea_v     = 1'b0;
    eb_v     = 1'b0;
    ea       = qlt_pkg::mk_res(qlt_pkg::KindToken, qlt_pkg::TokEnd, pos_q, '0, '0);
    eb       = ea;
    disp     = 1'b0;
    num_take = 1'b0;
    pt       = qlt_pkg::pair_type(pend_q, b);

    if (end_mark_i) begin
      case (mode_q)
        M_STRING: begin
          ea_v = 1'b1;
          ea   = qlt_pkg::mk_res(qlt_pkg::KindError, qlt_pkg::TokString, start_q,
                                 pos_q - start_q, '0);
        end
        M_NUMBER: begin
          ea_v = 1'b1;
          ea   = qlt_pkg::mk_res(qlt_pkg::KindToken, qlt_pkg::TokNumber, start_q,
                                 pos_q - start_q, '0);
        end
        M_IDENT: begin
          ea_v = 1'b1;
          ea   = qlt_pkg::mk_res(qlt_pkg::KindToken, qlt_pkg::TokIdent, start_q,
                                 pos_q - start_q, '0);
        end
        M_PEND: begin
          ea_v = 1'b1;
          ea   = qlt_pkg::mk_res(qlt_pkg::KindToken, qlt_pkg::single_type(pend_q),
                                 start_q, qlt_pkg::OffW'(1), '0);
        end
        default: ;
      endcase
      eb_v    = (mode_q != M_STRING);
      eb      = qlt_pkg::mk_res(qlt_pkg::KindToken, qlt_pkg::TokEnd, pos_q, '0, '0);
      mode_d  = M_IDLE;
      phase_d = PH_INT;
      pend_d  = '0;
      esc_d   = 1'b0;
      start_d = '0;
      pos_d   = '0;
    end else begin
      case (mode_q)
        M_COMMENT: begin
          if (b == qlt_pkg::ChLf) mode_d = M_IDLE;
        end
        M_STRING: begin
          if (esc_q) begin
            esc_d = 1'b0;
            ea_v  = 1'b1;
            ea    = qlt_pkg::mk_res(qlt_pkg::KindContent, qlt_pkg::TokString, start_q,
                                    '0, b);
          end else if (b == qlt_pkg::ChBslash) begin
            esc_d = 1'b1;
          end else if (b == qlt_pkg::ChQuote) begin
            ea_v   = 1'b1;
            ea     = qlt_pkg::mk_res(qlt_pkg::KindToken, qlt_pkg::TokString, start_q,
                                     pos_q + qlt_pkg::OffW'(1) - start_q, '0);
            mode_d = M_IDLE;
          end else begin
            ea_v = 1'b1;
            ea   = qlt_pkg::mk_res(qlt_pkg::KindContent, qlt_pkg::TokString, start_q,
                                   '0, b);
          end
        end
        M_NUMBER: begin
          case (phase_q)
            PH_INT: begin
              if (qlt_pkg::is_digit(b)) begin
                num_take = 1'b1;
              end else if (b == ".") begin
                num_take = 1'b1;
                phase_d  = PH_FRAC;
              end else if (b inside {"e", "E"}) begin
                num_take = 1'b1;
                phase_d  = PH_EXPSIGN;
              end
            end
            PH_FRAC: begin
              if (qlt_pkg::is_digit(b)) begin
                num_take = 1'b1;
              end else if (b inside {"e", "E"}) begin
                num_take = 1'b1;
                phase_d  = PH_EXPSIGN;
              end
            end
            PH_EXPSIGN: begin
              if (qlt_pkg::is_digit(b) || b inside {"+", "-"}) begin
                num_take = 1'b1;
                phase_d  = PH_EXPDIG;
              end
            end
            default: num_take = qlt_pkg::is_digit(b);
          endcase
          if (!num_take) begin
            ea_v = 1'b1;
            ea   = qlt_pkg::mk_res(qlt_pkg::KindToken, qlt_pkg::TokNumber, start_q,
                                   pos_q - start_q, '0);
            disp = 1'b1;
          end
        end
        M_IDENT: begin
          if (!qlt_pkg::extends_name(b)) begin
            ea_v = 1'b1;
            ea   = qlt_pkg::mk_res(qlt_pkg::KindToken, qlt_pkg::TokIdent, start_q,
                                   pos_q - start_q, '0);
            disp = 1'b1;
          end
        end
        M_PEND: begin
          if ((pend_q inside {"-", "."}) && qlt_pkg::is_digit(b)) begin
            mode_d  = M_NUMBER;
            phase_d = (pend_q == "-") ? PH_INT : PH_FRAC;
          end else if (pt != qlt_pkg::TokEnd) begin
            ea_v   = 1'b1;
            ea     = qlt_pkg::mk_res(qlt_pkg::KindToken, pt, start_q,
                                     qlt_pkg::OffW'(2), '0);
            mode_d = M_IDLE;
          end else begin
            ea_v = 1'b1;
            ea   = qlt_pkg::mk_res(qlt_pkg::KindToken, qlt_pkg::single_type(pend_q),
                                   start_q, qlt_pkg::OffW'(1), '0);
            disp = 1'b1;
          end
        end
        default: disp = 1'b1;
      endcase

      if (disp) begin
        mode_d = M_IDLE;
        if (qlt_pkg::is_space(b)) begin
          mode_d = M_IDLE;
        end else if (b == qlt_pkg::ChHash) begin
          mode_d = M_COMMENT;
        end else begin
          start_d = pos_q;
          if (b == qlt_pkg::ChQuote) begin
            mode_d = M_STRING;
            esc_d  = 1'b0;
          end else if (qlt_pkg::is_digit(b)) begin
            mode_d  = M_NUMBER;
            phase_d = PH_INT;
          end else if (qlt_pkg::starts_name(b)) begin
            mode_d = M_IDENT;
          end else if (qlt_pkg::is_pend_start(b)) begin
            mode_d = M_PEND;
            pend_d = b;
          end else begin
            eb_v = 1'b1;
            eb   = qlt_pkg::mk_res(qlt_pkg::KindToken, qlt_pkg::single_type(b), pos_q,
                                   qlt_pkg::OffW'(1), '0);
          end
        end
      end

      if (pos_q < qlt_pkg::PosLimit) pos_d = pos_q + qlt_pkg::OffW'(1);
    end
  end

  always_comb begin
    res_o.v0 = take_i && (ea_v || eb_v);
    res_o.v1 = take_i && ea_v && eb_v;
    res_o.r0 = ea_v ? ea : eb;
    res_o.r1 = eb;
    if (ea_v && eb_v) res_o.r1.last_of_run = 1'b1;
    else              res_o.r0.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      phase_q <= PH_INT;
      pend_q  <= '0;
      esc_q   <= 1'b0;
      start_q <= '0;
      pos_q   <= '0;
    end else if (take_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      pend_q  <= pend_d;
      esc_q   <= esc_d;
      start_q <= start_d;
      pos_q   <= pos_d;
    end
  end

endmodule

@@ rtl/qlt_outq.sv @@
// Four-entry result queue: takes up to two results a cycle, gives one when popped.
// Depends on qlt_pkg.
module qlt_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qlt_pkg::res_pair_t push_i,
  input  logic               pop_i,
  output logic               nearly_full_o,
  output logic               valid_o,
  output qlt_pkg::result_t   head_o
);

  qlt_pkg::result_t mem_q [4];
  logic [1:0]       wr_q, rd_q;
  logic [2:0]       cnt_q;
  logic [1:0]       n_push;
  logic             do_pop;

  assign n_push        = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign valid_o       = (cnt_q != 3'd0);
  assign do_pop        = pop_i && valid_o;
  assign nearly_full_o = (cnt_q > 3'd2);
  assign head_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wr_q] <= push_i.r0;
    if (push_i.v1) mem_q[wr_q + 2'd1] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push;
      rd_q  <= rd_q + {1'b0, do_pop};
      cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, do_pop};
    end
  end

endmodule

@@ rtl/query_language_tokenizer_top.sv @@
// Query tokenizer top level: scanner feeding a four-entry result queue.
// Depends on qlt_pkg, qlt_scan and qlt_outq.
// A word's results are registered in the queue and offered after earlier results.
// Throughput: one word per cycle unless in_stall_o; results leave at one per cycle
// unless out_stall_i is high, so two-result words fill the queue (stall at three or more).
// Reset (asynchronous, active low) clears scanner state, byte offset and queue.
module query_language_tokenizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_mark_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [5:0]  token_type_o,
  output logic [19:0] start_offset_o,
  output logic [19:0] token_length_o,
  output logic [7:0]  content_byte_o,
  output logic        last_of_run_o
);

  qlt_pkg::res_pair_t res;
  qlt_pkg::result_t   head;
  logic               take, nearly_full;

  assign in_stall_o = nearly_full;
  assign take       = in_valid_i && !nearly_full;

  qlt_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .in_byte_i  (in_byte_i),
    .end_mark_i (end_mark_i),
    .res_o      (res)
  );

  qlt_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (res),
    .pop_i         (!out_stall_i),
    .nearly_full_o (nearly_full),
    .valid_o       (out_valid_o),
    .head_o        (head)
  );

  assign kind_o         = head.kind;
  assign token_type_o   = head.token_type;
  assign start_offset_o = head.start_offset;
  assign token_length_o = head.token_length;
  assign content_byte_o = head.content_byte;
  assign last_of_run_o  = head.last_of_run;

endmodule

@@ rtl/qlt_checker.sv @@
// Port-level checks for the query tokenizer, bound to the top level.
// Depends on qlt_pkg and query_language_tokenizer_top.
module qlt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  in_byte_i,
  input logic        end_mark_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [5:0]  token_type_o,
  input logic [19:0] start_offset_o,
  input logic [19:0] token_length_o,
  input logic [7:0]  content_byte_o,
  input logic        last_of_run_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(token_type_o) && $stable(start_offset_o) && $stable(token_length_o) &&
      $stable(content_byte_o) && $stable(last_of_run_o))
    else $error("result word changed while stalled");

  a_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == qlt_pkg::KindContent |->
      token_type_o == qlt_pkg::TokString && token_length_o == '0)
    else $error("string content word with bad type or length");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == qlt_pkg::KindError |->
      last_of_run_o && token_type_o == qlt_pkg::TokString && content_byte_o == '0)
    else $error("unterminated string word malformed");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == qlt_pkg::KindToken && token_type_o == qlt_pkg::TokEnd |->
      last_of_run_o && token_length_o == '0)
    else $error("END word not last or has length");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_byte_i) && $stable(end_mark_i))
    else $error("input word changed while stalled");

endmodule

bind query_language_tokenizer_top qlt_checker u_qlt_checker (.*);
